// File: hdl/ssrr_pkg.sv
// shared constants, types and codes of the stream-aware rrip replacement block
`timescale 1ns / 1ps
package ssrr_pkg;

  localparam int SETS         = 2048;
  localparam int WAYS         = 16;
  localparam int SIG_BITS     = 6;
  localparam int DELTA_WINDOW = 8;

  localparam int SET_W   = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WAY_W   = $clog2(WAYS);
  localparam int PTR_W   = $clog2(DELTA_WINDOW);
  localparam int PAIR_W  = $clog2(DELTA_WINDOW);
  localparam int SIGS    = 1 << SIG_BITS;
  localparam int CLR_N   = (SETS > SIGS) ? SETS : SIGS;
  localparam int CLR_W   = $clog2(CLR_N);

  localparam int SET_IDX_W = 11;
  localparam int WAY_IN_W  = 4;
  localparam int ADDR_W    = 64;
  localparam int DELTA_W   = 32;
  localparam int LINE_OFF  = 6;
  localparam int STHR_W    = 4;
  localparam int RTHR_W    = 3;

  localparam logic [1:0] RRPV_TOP  = 2'd3;
  localparam logic [1:0] RRPV_NEAR = 2'd0;
  localparam logic [1:0] CTR_TOP   = 2'd3;
  localparam logic [1:0] CTR_RESET = 2'd1;
  localparam logic [STHR_W-1:0] STREAM_THR_RESET = 4'd6;
  localparam logic [RTHR_W-1:0] REUSE_THR_RESET  = 3'd1;

  typedef enum logic {
    CFG_STREAM_THR = 1'b0,
    CFG_REUSE_THR  = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CALC,
    ST_FIN
  } back_state_e;

  typedef struct packed {
    logic [STHR_W-1:0] stream_thr;
    logic [RTHR_W-1:0] reuse_thr;
  } cfg_t;

  typedef struct packed {
    logic                is_update;
    logic [SET_W-1:0]    set;
    logic [WAY_IN_W-1:0] way;
    logic [ADDR_W-1:0]   addr;
    logic                hit;
    logic [SIG_BITS-1:0] sig;
  } item_t;

  typedef struct packed {
    logic [WAYS-1:0][1:0]                 rrpv;
    logic [ADDR_W-1:0]                    last;
    logic [DELTA_WINDOW-1:0][DELTA_W-1:0] ring;
    logic [PTR_W-1:0]                     ptr;
  } row_t;

  localparam int ROW_W = $bits(row_t);

endpackage

// File: hdl/ssrr_if.sv
// request and result channel interfaces
`timescale 1ns / 1ps
interface ssrr_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [10:0] set_index;
  logic [3:0]  way;
  logic [63:0] addr;
  logic [63:0] pc;
  logic        hit;

  modport source (output valid, req_type, set_index, way, addr, pc, hit, input ready);
  modport sink   (input valid, req_type, set_index, way, addr, pc, hit, output ready);
endinterface

interface ssrr_rsp_if;
  logic       valid;
  logic       ready;
  logic [3:0] victim_way;
  logic [1:0] inserted_rrpv;
  logic       streaming;

  modport source (output valid, victim_way, inserted_rrpv, streaming, input ready);
  modport sink   (input valid, victim_way, inserted_rrpv, streaming, output ready);
endinterface

// File: hdl/ship_stream_rrip_replacement.sv
// top level of the stream-aware rrip last-level cache replacement block
// an accepted request is popped from the queue with its set read, then updated, then
// written back with its result registered once the result register is free
// the back end takes the next request only after that read-modify-write of the row ends
// the two-entry front queue takes requests while the back end works or stalls, until full
// reset: a clearing pass of max(SETS, 2^SIG_BITS) = 2048 entries initializes the row and
// counter memories; requests wait in the queue until it ends, config writes go through
`timescale 1ns / 1ps
module ship_stream_rrip_replacement (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [3:0] cfg_wdata_i,
  ssrr_req_if.sink   req_i,
  ssrr_rsp_if.source rsp_o
);
  // threshold registers
  ssrr_pkg::cfg_t  cfg_q;
  // queue between front and back
  logic            q_valid, q_ready;
  ssrr_pkg::item_t q_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.stream_thr <= ssrr_pkg::STREAM_THR_RESET;
      cfg_q.reuse_thr  <= ssrr_pkg::REUSE_THR_RESET;
    end else if (cfg_we_i) begin
      unique case (ssrr_pkg::cfg_idx_e'(cfg_idx_i))
        ssrr_pkg::CFG_STREAM_THR: cfg_q.stream_thr <= cfg_wdata_i;
        ssrr_pkg::CFG_REUSE_THR:  cfg_q.reuse_thr  <= cfg_wdata_i[2:0];
        default: begin
        end
      endcase
    end
  end

  // front: takes requests, derives set and signature
  ssrr_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req_i),
    .q_valid_o (q_valid),
    .q_ready_i (q_ready),
    .q_item_o  (q_item)
  );

  // back: victim search, detector, counters, result register
  ssrr_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .q_valid_i (q_valid),
    .q_ready_o (q_ready),
    .q_item_i  (q_item),
    .rsp_o     (rsp_o)
  );

  // the back end never takes two requests in consecutive cycles
  a_no_back_to_back_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_valid && q_ready) |=> !q_ready)
    else $error("back end popped twice in a row");

  // a result with a nonzero victim way carries no insertion info
  a_victim_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.victim_way != 4'd0) |-> (rsp_o.inserted_rrpv == 2'd0 &&
    !rsp_o.streaming))
    else $error("victim result with insertion fields set");

  // streaming insertion is always distant
  a_stream_distant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.streaming) |-> (rsp_o.inserted_rrpv == ssrr_pkg::RRPV_TOP))
    else $error("streaming miss not inserted distant");
endmodule

// File: hdl/ssrr_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
module ssrr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

// File: hdl/ssrr_front.sv
// front end: accepts requests, forms set and signature, two-entry queue
`timescale 1ns / 1ps
module ssrr_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  ssrr_req_if.sink             req_i,
  output logic                 q_valid_o,
  input  logic                 q_ready_i,
  output ssrr_pkg::item_t      q_item_o
);
  ssrr_pkg::item_t mem_q [2];
  ssrr_pkg::item_t in_item;
  logic       wp_q, wp_d, rp_q, rp_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  always_comb begin
    in_item.is_update = req_i.req_type;
    in_item.set  = ssrr_pkg::SET_W'(32'(req_i.set_index) % ssrr_pkg::SETS);
    in_item.way  = req_i.way;
    in_item.addr = req_i.addr;
    in_item.hit  = req_i.hit;
    in_item.sig  = ssrr_pkg::SIG_BITS'(req_i.pc ^ (req_i.addr >> ssrr_pkg::LINE_OFF));
  end

  assign req_i.ready = (cnt_q != 2'd2);
  assign push        = req_i.valid && req_i.ready;
  assign q_valid_o   = (cnt_q != 2'd0);
  assign pop         = q_valid_o && q_ready_i;
  assign q_item_o    = mem_q[rp_q];

  always_comb begin
    wp_d  = push ? ~wp_q : wp_q;
    rp_d  = pop ? ~rp_q : rp_q;
    cnt_d = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= in_item;
    end
  end
endmodule

// File: hdl/ssrr_back.sv
// back end: per-set read-modify-write sequencer, clearing pass, result register
`timescale 1ns / 1ps
module ssrr_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ssrr_pkg::cfg_t       cfg_i,
  input  logic                 q_valid_i,
  output logic                 q_ready_o,
  input  ssrr_pkg::item_t      q_item_i,
  ssrr_rsp_if.source           rsp_o
);
  ssrr_pkg::back_state_e state_q, state_d;
  logic [ssrr_pkg::CLR_W-1:0] clr_q;
  ssrr_pkg::item_t cur_q;
  ssrr_pkg::row_t  row_rd, row_q, calc_row, fin_row, row_wdata;
  logic [ssrr_pkg::WAY_W-1:0]  victim_q, calc_victim;
  logic [ssrr_pkg::PAIR_W-1:0] pairs_q, calc_pairs;
  logic [1:0] ctr_rd, ctr_new, ctr_wdata, rrpv_new;
  logic       streams, out_free, out_valid_q;
  logic       rd_en, row_we, ctr_we;
  logic [ssrr_pkg::SET_W-1:0]    row_waddr;
  logic [ssrr_pkg::SIG_BITS-1:0] ctr_waddr;
  logic [ssrr_pkg::ROW_W-1:0]    row_rd_raw;
  logic       found3, found2;
  logic [ssrr_pkg::WAY_W-1:0] idx3, idx2;
  logic [ssrr_pkg::DELTA_W-1:0] delta;
  logic [3:0] out_victim_q;
  logic [1:0] out_rrpv_q;
  logic       out_stream_q;

  ssrr_ram #(.WIDTH(ssrr_pkg::ROW_W), .DEPTH(ssrr_pkg::SETS)) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (row_we),
    .waddr_i (row_waddr),
    .wdata_i (row_wdata),
    .re_i    (rd_en),
    .raddr_i (q_item_i.set),
    .rdata_o (row_rd_raw)
  );

  ssrr_ram #(.WIDTH(2), .DEPTH(ssrr_pkg::SIGS)) u_ctr_ram (
    .clk_i   (clk_i),
    .we_i    (ctr_we),
    .waddr_i (ctr_waddr),
    .wdata_i (ctr_wdata),
    .re_i    (rd_en),
    .raddr_i (q_item_i.sig),
    .rdata_o (ctr_rd)
  );

  assign row_rd   = ssrr_pkg::row_t'(row_rd_raw);
  assign out_free = !out_valid_q || rsp_o.ready;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ssrr_pkg::ST_CLEAR: begin
        if (clr_q == ssrr_pkg::CLR_W'(ssrr_pkg::CLR_N - 1)) state_d = ssrr_pkg::ST_IDLE;
      end
      ssrr_pkg::ST_IDLE: begin
        if (q_valid_i) state_d = ssrr_pkg::ST_CALC;
      end
      ssrr_pkg::ST_CALC: begin
        state_d = ssrr_pkg::ST_FIN;
      end
      ssrr_pkg::ST_FIN: begin
        if (out_free) state_d = ssrr_pkg::ST_IDLE;
      end
      default: state_d = ssrr_pkg::ST_CLEAR;
    endcase
  end

  // memory controls
  always_comb begin
    q_ready_o = 1'b0;
    rd_en     = 1'b0;
    row_we    = 1'b0;
    ctr_we    = 1'b0;
    row_waddr = cur_q.set;
    ctr_waddr = cur_q.sig;
    row_wdata = fin_row;
    ctr_wdata = ctr_new;
    unique case (state_q)
      ssrr_pkg::ST_CLEAR: begin
        row_we    = 32'(clr_q) < ssrr_pkg::SETS;
        ctr_we    = 32'(clr_q) < ssrr_pkg::SIGS;
        row_waddr = ssrr_pkg::SET_W'(clr_q);
        ctr_waddr = ssrr_pkg::SIG_BITS'(clr_q);
        row_wdata = '0;
        row_wdata.rrpv = '1;
        ctr_wdata = ssrr_pkg::CTR_RESET;
      end
      ssrr_pkg::ST_IDLE: begin
        q_ready_o = 1'b1;
        rd_en     = q_valid_i;
      end
      ssrr_pkg::ST_CALC: begin
      end
      ssrr_pkg::ST_FIN: begin
        row_we = out_free;
        ctr_we = out_free && cur_q.is_update;
      end
      default: begin
      end
    endcase
  end

  // victim search, aging and detector training
  always_comb begin
    found3 = 1'b0;
    found2 = 1'b0;
    idx3   = '0;
    idx2   = '0;
    for (int w = ssrr_pkg::WAYS - 1; w >= 0; w--) begin
      if (row_rd.rrpv[w] == ssrr_pkg::RRPV_TOP) begin
        found3 = 1'b1;
        idx3   = ssrr_pkg::WAY_W'(w);
      end
      if (row_rd.rrpv[w] == 2'd2) begin
        found2 = 1'b1;
        idx2   = ssrr_pkg::WAY_W'(w);
      end
    end
    delta = (row_rd.last == '0) ? '0 : ssrr_pkg::DELTA_W'(cur_q.addr - row_rd.last);
    calc_row    = row_rd;
    calc_victim = '0;
    calc_pairs  = '0;
    if (!cur_q.is_update) begin
      if (found3) begin
        calc_victim = idx3;
      end else begin
        // nothing distant: age the set, the first line that was at 2 wins
        for (int w = 0; w < ssrr_pkg::WAYS; w++) begin
          calc_row.rrpv[w] = row_rd.rrpv[w] + 2'd1;
        end
        calc_victim = found2 ? idx2 : '0;
      end
    end else begin
      calc_row.last = cur_q.addr;
      calc_row.ring[row_rd.ptr] = delta;
      calc_row.ptr = (32'(row_rd.ptr) == ssrr_pkg::DELTA_WINDOW - 1) ? '0 :
                     row_rd.ptr + ssrr_pkg::PTR_W'(1);
      for (int i = 1; i < ssrr_pkg::DELTA_WINDOW; i++) begin
        if (calc_row.ring[i-1] == calc_row.ring[i] && calc_row.ring[i-1] != '0) begin
          calc_pairs = calc_pairs + ssrr_pkg::PAIR_W'(1);
        end
      end
    end
  end

  // insertion and counter training
  always_comb begin
    streams  = !cur_q.hit && (32'(pairs_q) >= 32'(cfg_i.stream_thr));
    rrpv_new = ssrr_pkg::RRPV_NEAR;
    ctr_new  = ctr_rd;
    if (cur_q.hit) begin
      if (ctr_rd < ssrr_pkg::CTR_TOP) ctr_new = ctr_rd + 2'd1;
    end else begin
      if (streams) begin
        rrpv_new = ssrr_pkg::RRPV_TOP;
      end else begin
        rrpv_new = ({1'b0, ctr_rd} >= cfg_i.reuse_thr) ? ssrr_pkg::RRPV_NEAR
                                                       : ssrr_pkg::RRPV_TOP;
      end
      if (ctr_rd != 2'd0) ctr_new = ctr_rd - 2'd1;
    end
    fin_row = row_q;
    if (cur_q.is_update && (32'(cur_q.way) < ssrr_pkg::WAYS)) begin
      fin_row.rrpv[ssrr_pkg::WAY_W'(cur_q.way)] = rrpv_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ssrr_pkg::ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ssrr_pkg::ST_CLEAR) clr_q <= clr_q + ssrr_pkg::CLR_W'(1);
      if (state_q == ssrr_pkg::ST_FIN && out_free) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) cur_q <= q_item_i;
    if (state_q == ssrr_pkg::ST_CALC) begin
      row_q    <= calc_row;
      victim_q <= calc_victim;
      pairs_q  <= calc_pairs;
    end
    if (state_q == ssrr_pkg::ST_FIN && out_free) begin
      out_victim_q <= cur_q.is_update ? 4'd0 : 4'(victim_q);
      out_rrpv_q   <= cur_q.is_update ? rrpv_new : 2'd0;
      out_stream_q <= cur_q.is_update && streams;
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.victim_way    = out_victim_q;
  assign rsp_o.inserted_rrpv = out_rrpv_q;
  assign rsp_o.streaming     = out_stream_q;
endmodule

// File: test/testbench.sv
// testbench of the stream-aware rrip replacement block: directed table, random traffic, predictor
`timescale 1ns / 1ps
module testbench;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_idx_i;
  logic [3:0] cfg_wdata_i;

  ssrr_req_if req_if ();
  ssrr_rsp_if rsp_if ();

  ship_stream_rrip_replacement DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i), .req_i(req_if.sink), .rsp_o(rsp_if.source)
  );

  // one request as driven on the channel
  typedef struct {
    logic        upd;
    logic [10:0] set;
    logic [3:0]  way;
    logic [63:0] addr;
    logic [63:0] pc;
    logic        hit;
  } access_t;

  // one result
  typedef struct {
    logic [3:0] victim;
    logic [1:0] rrpv;
    logic       strm;
  } outcome_t;

  // shadow copy of the replacement state
  logic [1:0]  shadow_rrpv [ssrr_pkg::SETS][ssrr_pkg::WAYS];
  logic [1:0]  shadow_ctr  [ssrr_pkg::SIGS];
  logic [63:0] shadow_last [ssrr_pkg::SETS];
  logic [31:0] shadow_ring [ssrr_pkg::SETS][ssrr_pkg::DELTA_WINDOW];
  logic [2:0]  shadow_ptr  [ssrr_pkg::SETS];
  logic [3:0]  stream_thr;
  logic [2:0]  reuse_thr;

  outcome_t pending_results[$];
  access_t  drive_queue[$];
  int       mismatches;
  int       idle_cycles;
  int       send_idle_pct;
  int       recv_idle_pct;
  bit       hold_off;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic shadow_reset();
    stream_thr = ssrr_pkg::STREAM_THR_RESET;
    reuse_thr  = ssrr_pkg::REUSE_THR_RESET;
    foreach (shadow_rrpv[s, w]) shadow_rrpv[s][w] = ssrr_pkg::RRPV_TOP;
    foreach (shadow_ctr[i]) shadow_ctr[i] = ssrr_pkg::CTR_RESET;
    foreach (shadow_last[s]) begin
      shadow_last[s] = '0;
      shadow_ptr[s]  = '0;
    end
    foreach (shadow_ring[s, i]) shadow_ring[s][i] = '0;
  endtask

  // next result of the replacement policy, updating the shadow state
  function automatic outcome_t predict_replacement(access_t a);
    outcome_t r;
    int unsigned s;
    int unsigned pairs;
    logic [31:0] delta;
    logic [ssrr_pkg::SIG_BITS-1:0] sig;
    int w;
    s = a.set;
    r = '{victim: 4'd0, rrpv: 2'd0, strm: 1'b0};
    if (!a.upd) begin
      w = -1;
      for (int i = 0; i < ssrr_pkg::WAYS; i++)
        if (w < 0 && shadow_rrpv[s][i] == ssrr_pkg::RRPV_TOP) w = i;
      if (w < 0) begin
        // nothing distant: age the whole set and search again
        for (int i = 0; i < ssrr_pkg::WAYS; i++)
          if (shadow_rrpv[s][i] < ssrr_pkg::RRPV_TOP) shadow_rrpv[s][i]++;
        for (int i = 0; i < ssrr_pkg::WAYS; i++)
          if (w < 0 && shadow_rrpv[s][i] == ssrr_pkg::RRPV_TOP) w = i;
        if (w < 0) w = 0;
      end
      r.victim = w[3:0];
      return r;
    end
    // first touch of a set records a zero delta
    delta = (shadow_last[s] == 0) ? 32'd0 : 32'(a.addr - shadow_last[s]);
    shadow_last[s] = a.addr;
    shadow_ring[s][shadow_ptr[s]] = delta;
    shadow_ptr[s]++;
    pairs = 0;
    // neighbours in slot order, not ring order
    for (int i = 1; i < ssrr_pkg::DELTA_WINDOW; i++)
      if (shadow_ring[s][i-1] == shadow_ring[s][i] && shadow_ring[s][i] != 0) pairs++;
    sig = a.pc[ssrr_pkg::SIG_BITS-1:0] ^ a.addr[ssrr_pkg::LINE_OFF +: ssrr_pkg::SIG_BITS];
    if (a.hit) begin
      r.rrpv = ssrr_pkg::RRPV_NEAR;
      if (shadow_ctr[sig] < ssrr_pkg::CTR_TOP) shadow_ctr[sig]++;
    end else begin
      r.strm = (pairs >= stream_thr);
      if (r.strm) r.rrpv = ssrr_pkg::RRPV_TOP;
      else r.rrpv = ({1'b0, shadow_ctr[sig]} >= reuse_thr) ? ssrr_pkg::RRPV_NEAR
                                                            : ssrr_pkg::RRPV_TOP;
      if (shadow_ctr[sig] > 0) shadow_ctr[sig]--;
    end
    if (a.way < ssrr_pkg::WAYS) shadow_rrpv[s][a.way] = r.rrpv;
    return r;
  endfunction

  function automatic access_t random_access(logic [10:0] set_pick, logic [63:0] base, int k);
    access_t a;
    a.upd  = $urandom_range(0, 99) < 60;
    a.set  = set_pick;
    a.way  = 4'($urandom_range(0, 15));
    a.addr = base + 64'(k) * 64;
    a.pc   = {$urandom, $urandom};
    a.hit  = 1'($urandom_range(0, 1));
    return a;
  endfunction

  // request driver: changes on the falling edge, holds a request until it is taken
  initial begin
    req_if.valid = 1'b0;
    req_if.req_type = 1'b0;
    req_if.set_index = '0;
    req_if.way = '0;
    req_if.addr = '0;
    req_if.pc = '0;
    req_if.hit = 1'b0;
    forever begin
      @(negedge clk_i);
      if (drive_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        access_t a;
        a = drive_queue.pop_front();
        req_if.valid = 1'b1;
        req_if.req_type = a.upd;
        req_if.set_index = a.set;
        req_if.way = a.way;
        req_if.addr = a.addr;
        req_if.pc = a.pc;
        req_if.hit = a.hit;
        @(posedge clk_i);
        while (!req_if.ready) @(posedge clk_i);
      end else begin
        req_if.valid = 1'b0;
      end
    end
  end

  // result ready: random stalls, or a long hold-off when asked
  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      rsp_if.ready <= !hold_off && ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // accepted requests feed the predictor, accepted results are checked
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) begin
        access_t a;
        a = '{upd: req_if.req_type, set: req_if.set_index, way: req_if.way,
              addr: req_if.addr, pc: req_if.pc, hit: req_if.hit};
        pending_results.push_back(predict_replacement(a));
      end
      if (rsp_if.valid && rsp_if.ready) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result way=%0d", rsp_if.victim_way);
        end else begin
          outcome_t e;
          e = pending_results.pop_front();
          if (e.victim !== rsp_if.victim_way || e.rrpv !== rsp_if.inserted_rrpv ||
              e.strm !== rsp_if.streaming) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp way=%0d rrpv=%0d strm=%0d got way=%0d rrpv=%0d strm=%0d",
                       e.victim, e.rrpv, e.strm, rsp_if.victim_way,
                       rsp_if.inserted_rrpv, rsp_if.streaming);
          end
        end
      end
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) idle_cycles = 0;
      else idle_cycles++;
    end
  end

  // watchdog: clearing pass plus long hold-offs fit well inside the limit
  initial begin
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (idle_cycles > 20000) begin
        $display("testbench: done, errors");
        $finish;
      end
    end
  end

  task automatic wait_drained();
    wait (drive_queue.size() == 0);
    while (req_if.valid || pending_results.size() > 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_cfg(ssrr_pkg::cfg_idx_e idx, logic [3:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == ssrr_pkg::CFG_STREAM_THR) stream_thr = val;
    else reuse_thr = val[2:0];
  endtask

  // one streaming run of updates on a set with a constant stride
  task automatic queue_stream(logic [10:0] set_pick, int n);
    logic [63:0] base;
    base = {$urandom, $urandom};
    for (int k = 0; k < n; k++) begin
      access_t a;
      a = random_access(set_pick, base, k);
      a.upd = 1'b1;
      drive_queue.push_back(a);
    end
  endtask

  initial begin
    // directed rows: request, expected result, whether the expectation is typed in
    access_t  dir_req[16];
    outcome_t dir_exp[16];
    bit       dir_known[16];
    int       n_items;
    logic [10:0] hot_sets[4];

    mismatches = 0;
    idle_cycles = 0;
    hold_off = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    cfg_we_i = 1'b0;
    cfg_idx_i = ssrr_pkg::CFG_STREAM_THR;
    cfg_wdata_i = '0;
    shadow_reset();
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // after reset every line is distant, so victims come out as way 0
    dir_req[0] = '{1'b0, 11'd0, 4'd0, 64'd0, 64'd0, 1'b0};
    dir_req[1] = '{1'b0, 11'h7ff, 4'hf, '1, '1, 1'b1};
    // miss fill with counter at reset value 1 and threshold 1 inserts near
    dir_req[2] = '{1'b1, 11'd5, 4'd0, 64'h40, 64'd0, 1'b0};
    dir_req[3] = '{1'b1, 11'd5, 4'd1, 64'h80, 64'h3f, 1'b1};
    dir_req[4] = '{1'b0, 11'd5, 4'd0, 64'd0, 64'd0, 1'b0};
    dir_req[5] = '{1'b1, 11'h7ff, 4'hf, '1, '1, 1'b0};
    dir_req[6] = '{1'b1, 11'h7ff, 4'd3, 64'h0, 64'h0, 1'b1};
    dir_req[7] = '{1'b0, 11'h7ff, 4'd0, 64'd0, 64'd0, 1'b0};
    for (int i = 8; i < 16; i++) dir_req[i] = '{1'b1, 11'd9, 4'(i), 64'(i) * 64'h100,
                                                  64'h5, 1'b0};
    foreach (dir_known[i]) dir_known[i] = 1'b0;
    dir_exp[0] = '{4'd0, 2'd0, 1'b0}; dir_known[0] = 1'b1;
    dir_exp[1] = '{4'd0, 2'd0, 1'b0}; dir_known[1] = 1'b1;
    dir_exp[3] = '{4'd0, 2'd0, 1'b0}; dir_known[3] = 1'b1;

    send_idle_pct = 26;
    recv_idle_pct = 79;
    for (int i = 0; i < 16; i++) drive_queue.push_back(dir_req[i]);
    wait_drained();

    // typed-in rows are also compared against the predictor's view
    shadow_reset();
    for (int i = 0; i < 16; i++) begin
      outcome_t p;
      p = predict_replacement(dir_req[i]);
      if (dir_known[i] && (p.victim !== dir_exp[i].victim || p.rrpv !== dir_exp[i].rrpv ||
                           p.strm !== dir_exp[i].strm)) begin
        mismatches++;
        if (mismatches <= 10)
          $display("table row %0d: exp way=%0d rrpv=%0d strm=%0d got way=%0d rrpv=%0d strm=%0d",
                   i, dir_exp[i].victim, dir_exp[i].rrpv, dir_exp[i].strm,
                   p.victim, p.rrpv, p.strm);
      end
    end

    hot_sets = '{11'd1, 11'd2, 11'h400, 11'h7fe};
    n_items = 0;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          write_cfg(ssrr_pkg::CFG_STREAM_THR, 4'd0);
          write_cfg(ssrr_pkg::CFG_REUSE_THR, 4'd0);
        end
        1: begin
          send_idle_pct = 79;
          recv_idle_pct = 26;
          write_cfg(ssrr_pkg::CFG_STREAM_THR, 4'd8);
          write_cfg(ssrr_pkg::CFG_REUSE_THR, 4'd4);
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          write_cfg(ssrr_pkg::CFG_STREAM_THR, 4'd3);
          write_cfg(ssrr_pkg::CFG_REUSE_THR, 4'd2);
        end
      endcase
      for (int b = 0; b < 250; ) begin
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 5) begin
          // well-formed stream of updates on a hot set
          queue_stream(hot_sets[$urandom_range(0, 3)], 10);
          b += 10;
        end else if (pick < 8) begin
          drive_queue.push_back(random_access(hot_sets[$urandom_range(0, 3)],
                                              {$urandom, $urandom}, 0));
          b++;
        end else begin
          drive_queue.push_back(random_access(11'($urandom), {$urandom, $urandom}, 0));
          b++;
        end
      end
      if (phase == 2) begin
        // long receiver hold-off while requests keep coming
        @(negedge clk_i);
        hold_off <= 1'b1;
        repeat (300) @(negedge clk_i);
        hold_off <= 1'b0;
      end
      wait_drained();
    end

    if (mismatches == 0) $display("testbench: done, clean");
    else $display("testbench: done, errors");
    $finish;
  end

endmodule
